@@ rtl/ptrpd_pkg.sv @@
// shared types, constants and helpers of the planar tile row palette decoder
// no dependencies
package ptrpd_pkg;

  localparam int unsigned COLOUR_RAM_BYTES_DEF = 512;
  localparam int unsigned LANES                = 8;
  localparam int unsigned PIXEL_W              = 24;
  localparam int unsigned WORD_ADDR_MAX_W      = 8;

  localparam logic [PIXEL_W-1:0] BACKDROP_RGB = 24'h101018;
  localparam logic [PIXEL_W-1:0] MISSING_RGB  = 24'hFF00FF;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_DECODE = 1'b1
  } ptrpd_cmd_e;

  // colour ram write request, shared by all lane copies
  typedef struct packed {
    logic                       lo_we;
    logic                       hi_we;
    logic [WORD_ADDR_MAX_W-1:0] word_addr;
    logic [7:0]                 data;
  } ptrpd_wr_t;

  // 5-bit channel to 8 bits by bit replication
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

@@ rtl/ptrpd_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module ptrpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptrpd_lane.sv @@
// one pixel lane: entry address, private colour ram copy, channel expansion
// depends on ptrpd_pkg and ptrpd_ram
module ptrpd_lane
  import ptrpd_pkg::*;
#(
  parameter int unsigned COLOUR_RAM_BYTES = COLOUR_RAM_BYTES_DEF
) (
  input  logic               clk_i,
  input  ptrpd_wr_t          wr_i,
  input  logic               rd_en_i,
  input  logic               four_bit_mode_i,
  input  logic [3:0]         index_i,
  input  logic [7:0]         palette_i,
  output logic [PIXEL_W-1:0] rgb_o
);

  localparam int unsigned WORDS = (COLOUR_RAM_BYTES + 1) / 2;
  localparam int unsigned WA    = $clog2(WORDS);

  logic [11:0] entry;
  logic        backdrop;
  logic        missing;
  logic        backdrop_q;
  logic        missing_q;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [15:0] c16;

  always_comb begin
    if (four_bit_mode_i) begin
      entry = {palette_i, index_i};
    end else begin
      entry = {2'b00, palette_i, index_i[1:0]};
    end
    backdrop = (index_i == 4'd0);
    // high byte of the entry must lie inside the store
    missing  = ({entry, 1'b1} >= 13'(COLOUR_RAM_BYTES));
  end

  ptrpd_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (wr_i.lo_we),
    .waddr_i (wr_i.word_addr[WA-1:0]),
    .wdata_i (wr_i.data),
    .re_i    (rd_en_i),
    .raddr_i (entry[WA-1:0]),
    .rdata_o (lo_byte)
  );

  ptrpd_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (wr_i.hi_we),
    .waddr_i (wr_i.word_addr[WA-1:0]),
    .wdata_i (wr_i.data),
    .re_i    (rd_en_i),
    .raddr_i (entry[WA-1:0]),
    .rdata_o (hi_byte)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      backdrop_q <= backdrop;
      missing_q  <= missing;
    end
  end

  assign c16 = {hi_byte, lo_byte};

  always_comb begin
    if (backdrop_q) begin
      rgb_o = BACKDROP_RGB;
    end else if (missing_q) begin
      rgb_o = MISSING_RGB;
    end else begin
      rgb_o = {expand5(c16[4:0]), expand5(c16[9:5]), expand5(c16[14:10])};
    end
  end

endmodule

@@ rtl/planar_tile_row_palette_decoder.sv @@
// top level of the planar tile row palette decoder: stream control, clear pass,
// eight pixel lanes and the output register; depends on ptrpd_pkg and ptrpd_lane
//
// usage
//   slave stream s_axis_*: one transaction is either a colour ram byte write
//   (tuser = 0) or a tile row decode (tuser = 1); write transactions give no
//   result, each decode transaction gives one master transaction on m_axis_*
//   carrying eight 24-bit rgb pixels, leftmost pixel in the lowest bits
//   configuration: cfg_we_i writes cfg_wdata_i into four_bit_mode
//   (1 = four bitplanes, 16-colour palettes; 0 = two planes, 4-colour palettes)
// throughput and pipeline
//   one transaction per cycle sustained while the output is not stalled; a decode
//   reads the colour ram at the accepting edge and is then loaded into the output
//   register, which raises m_axis_tvalid
//   every lane owns a copy of the colour ram, so all eight lookups share a cycle
// reset
//   after rst_ni releases, a clearing pass zeroes all (COLOUR_RAM_BYTES+1)/2 words
//   of the colour ram (256 at the default size), one word per cycle, with
//   s_axis_tready low; four_bit_mode resets to 1
// stall
//   a stalled result holds in the output register while the next decode waits
//   in the ram read stage; only then does s_axis_tready drop
module planar_tile_row_palette_decoder
  import ptrpd_pkg::*;
#(
  parameter int unsigned COLOUR_RAM_BYTES = COLOUR_RAM_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  // slave stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // fields from bit 0: colour_ram_address[8:0], colour_ram_byte, plane_zero,
  // plane_one, plane_two, plane_three, palette_number, zero fill
  input  logic [63:0]                s_axis_tdata,
  // fields from bit 0: command
  input  logic                       s_axis_tuser,
  // master stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // fields from bit 0: pixel_zero .. pixel_seven, 24 bits each
  output logic [LANES*PIXEL_W-1:0]   m_axis_tdata
);

  localparam int unsigned WORDS = (COLOUR_RAM_BYTES + 1) / 2;
  localparam int unsigned WA    = $clog2(WORDS);

  // input field views
  logic [8:0] in_addr;
  logic [7:0] in_byte;
  logic [7:0] plane0;
  logic [7:0] plane1;
  logic [7:0] plane2;
  logic [7:0] plane3;
  logic [7:0] in_palette;

  assign in_addr    = s_axis_tdata[8:0];
  assign in_byte    = s_axis_tdata[16:9];
  assign plane0     = s_axis_tdata[24:17];
  assign plane1     = s_axis_tdata[32:25];
  assign plane2     = s_axis_tdata[40:33];
  assign plane3     = s_axis_tdata[48:41];
  assign in_palette = s_axis_tdata[56:49];

  // configuration register
  logic four_bit_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      four_bit_mode_q <= cfg_wdata_i;
    end
  end

  // clearing pass after reset
  logic          clear_q;
  logic          clear_d;
  logic [WA-1:0] clear_cnt_q;
  logic [WA-1:0] clear_cnt_d;

  always_comb begin
    clear_d     = clear_q;
    clear_cnt_d = clear_cnt_q;
    if (clear_q) begin
      clear_cnt_d = clear_cnt_q + 1'b1;
      if (clear_cnt_q == WA'(WORDS - 1)) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clear_cnt_q <= '0;
    end else begin
      clear_q     <= clear_d;
      clear_cnt_q <= clear_cnt_d;
    end
  end

  // pipeline control: ram read stage, then output register
  logic s1_valid_q;
  logic s1_valid_d;
  logic out_valid_q;
  logic out_valid_d;
  logic s2_load;
  logic s1_advance;
  logic in_acc;
  logic wr_acc;
  logic rd_acc;
  logic in_range;

  assign s2_load       = !out_valid_q || m_axis_tready;
  assign s1_advance    = s1_valid_q && s2_load;
  assign s_axis_tready = !clear_q && (!s1_valid_q || s1_advance);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_acc        = in_acc && (ptrpd_cmd_e'(s_axis_tuser) == CMD_WRITE);
  assign rd_acc        = in_acc && (ptrpd_cmd_e'(s_axis_tuser) == CMD_DECODE);
  // writes at or beyond the store size are dropped
  assign in_range      = ({1'b0, in_addr} < 10'(COLOUR_RAM_BYTES));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // write request broadcast to every lane copy
  ptrpd_wr_t wr;

  always_comb begin
    if (clear_q) begin
      wr.lo_we     = 1'b1;
      wr.hi_we     = 1'b1;
      wr.word_addr = WORD_ADDR_MAX_W'(clear_cnt_q);
      wr.data      = '0;
    end else begin
      wr.lo_we     = wr_acc && in_range && !in_addr[0];
      wr.hi_we     = wr_acc && in_range && in_addr[0];
      wr.word_addr = in_addr[8:1];
      wr.data      = in_byte;
    end
  end

  // lanes, lane i takes bit 7-i of every plane; upper planes masked in 2bpp
  logic [PIXEL_W-1:0] lane_rgb [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [3:0] index;

    assign index = {plane3[LANES-1-i] & four_bit_mode_q,
                    plane2[LANES-1-i] & four_bit_mode_q,
                    plane1[LANES-1-i],
                    plane0[LANES-1-i]};

    ptrpd_lane #(.COLOUR_RAM_BYTES(COLOUR_RAM_BYTES)) u_lane (
      .clk_i           (clk_i),
      .wr_i            (wr),
      .rd_en_i         (rd_acc),
      .four_bit_mode_i (four_bit_mode_q),
      .index_i         (index),
      .palette_i       (in_palette),
      .rgb_o           (lane_rgb[i])
    );
  end

  // merging stage: pack the lanes into the output register
  logic [LANES*PIXEL_W-1:0] pixels_q;
  logic [LANES*PIXEL_W-1:0] pixels_d;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pixels_d[i*PIXEL_W +: PIXEL_W] = lane_rgb[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      pixels_q <= pixels_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pixels_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !s_axis_tready)
    else $error("transaction accepted during clearing pass");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_load) |-> !s_axis_tready)
    else $error("input accepted while read stage is stalled");

  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_load) |=> s1_valid_q)
    else $error("stalled read stage lost its decode");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a decode in the read stage");

endmodule

@@ bench/ptrpd_checker.sv @@
// row checker for the planar tile row palette decoder bench: tracks the colour ram
// and plane mode, predicts every decoded row and compares it; depends on ptrpd_pkg
`timescale 1ns / 100ps

module ptrpd_checker
  import ptrpd_pkg::*;
#(
  parameter int unsigned RAM_BYTES = COLOUR_RAM_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  input  logic [63:0]              s_tdata_i,
  input  logic                     s_tuser_i,
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  input  logic [LANES*PIXEL_W-1:0] m_tdata_i,
  input  logic                     run_over_i,
  output int                       error_count_o,
  output int                       pending_o
);

  localparam int unsigned AW = $clog2(RAM_BYTES);

  typedef logic [LANES*PIXEL_W-1:0] pixel_row_t;

  string pixel_name [LANES] = '{"pixel_zero", "pixel_one", "pixel_two", "pixel_three",
                                "pixel_four", "pixel_five", "pixel_six", "pixel_seven"};

  logic [7:0]  colour_mem [RAM_BYTES];
  logic        four_plane_mode;
  pixel_row_t  row_queue [$];
  int          fail_total;
  bit          leftover_checked;

  // 15-bit colour word to 24-bit rgb, top bits of each channel repeated below
  function automatic logic [PIXEL_W-1:0] widen_colour(input logic [15:0] word);
    logic [4:0] red, green, blue;
    red   = word[4:0];
    green = word[9:5];
    blue  = word[14:10];
    return {red, red[4:2], green, green[4:2], blue, blue[4:2]};
  endfunction

  function automatic pixel_row_t predict_row(input logic [7:0] p0, input logic [7:0] p1,
                                              input logic [7:0] p2, input logic [7:0] p3,
                                              input logic [7:0] palette);
    pixel_row_t  row;
    logic [3:0]  colour_index;
    logic [2:0]  bitpos;
    int unsigned entry, low_byte;
    for (int px = 0; px < LANES; px++) begin
      bitpos       = 3'(7 - px);
      colour_index = {p3[bitpos] & four_plane_mode, p2[bitpos] & four_plane_mode,
                      p1[bitpos], p0[bitpos]};
      if (colour_index == 4'd0) begin
        row[px*PIXEL_W +: PIXEL_W] = BACKDROP_RGB;
      end else begin
        entry    = palette * (four_plane_mode ? 16 : 4) + colour_index;
        low_byte = entry * 2;
        if (low_byte + 1 < RAM_BYTES) begin
          row[px*PIXEL_W +: PIXEL_W] =
            widen_colour({colour_mem[AW'(low_byte + 1)], colour_mem[AW'(low_byte)]});
        end else begin
          row[px*PIXEL_W +: PIXEL_W] = MISSING_RGB;
        end
      end
    end
    return row;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_row_t  want;
    logic [8:0]  wr_addr;
    if (!rst_ni) begin
      for (int i = 0; i < RAM_BYTES; i++) colour_mem[AW'(i)] = 8'd0;
      four_plane_mode  = 1'b1;
      row_queue.delete();
      fail_total       = 0;
      leftover_checked = 1'b0;
      error_count_o   <= 0;
      pending_o       <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (row_queue.size() == 0) begin
          $error("pixel row %h arrived with no decode waiting", m_tdata_i);
          fail_total++;
        end else begin
          want = row_queue.pop_front();
          for (int px = 0; px < LANES; px++) begin
            if (m_tdata_i[px*PIXEL_W +: PIXEL_W] !== want[px*PIXEL_W +: PIXEL_W]) begin
              $error("%s expected %06h actual %06h", pixel_name[px],
                     want[px*PIXEL_W +: PIXEL_W], m_tdata_i[px*PIXEL_W +: PIXEL_W]);
              fail_total++;
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == CMD_DECODE) begin
          row_queue.push_back(predict_row(s_tdata_i[24:17], s_tdata_i[32:25],
                                          s_tdata_i[40:33], s_tdata_i[48:41],
                                          s_tdata_i[56:49]));
        end else begin
          wr_addr = s_tdata_i[8:0];
          if (wr_addr < RAM_BYTES) colour_mem[AW'(wr_addr)] = s_tdata_i[16:9];
        end
      end
      if (cfg_we_i) four_plane_mode = cfg_wdata_i;
      if (run_over_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (row_queue.size() != 0) begin
          $error("%0d decoded rows never arrived", row_queue.size());
          fail_total += row_queue.size();
        end
      end
      error_count_o <= fail_total;
      pending_o     <= row_queue.size();
    end
  end

endmodule

@@ bench/planar_tile_row_palette_decoder_tb.sv @@
// top of the planar tile row palette decoder bench: clock, reset, stimulus and verdict
// depends on ptrpd_pkg, ptrpd_checker and the decoder rtl
`timescale 1ns / 100ps

module planar_tile_row_palette_decoder_tb
  import ptrpd_pkg::*;
;

  localparam int unsigned RAM_BYTES    = 512;
  localparam int unsigned PHASE_ITEMS  = 500;   // four random phases
  localparam int unsigned IDLE_LIMIT   = 5000;  // covers the clearing pass and long stalls
  localparam int unsigned SETTLE_TICKS = 4;     // two-stage pipeline plus margin
  localparam int unsigned DRAIN_TICKS  = 8;

  // receiver behavior, changed at random after each stretch of random length
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_style_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // fields from bit 0: colour_ram_address[8:0], colour_ram_byte, plane_zero,
  // plane_one, plane_two, plane_three, palette_number, zero fill
  logic [63:0]              s_axis_tdata;
  // fields from bit 0: command
  logic                     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // fields from bit 0: pixel_zero .. pixel_seven, 24 bits each
  logic [LANES*PIXEL_W-1:0] m_axis_tdata;

  logic                     run_over;
  int                       fail_count;
  int                       rows_pending;

  int unsigned              burst_left   = 0;
  int unsigned              writes_sent  = 0;
  int unsigned              rows_sent    = 0;
  int unsigned              mode_writes  = 0;
  int unsigned              idle_cycles  = 0;
  stall_style_e             stall_style  = STALL_NONE;
  int unsigned              style_left   = 0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  planar_tile_row_palette_decoder #(
    .COLOUR_RAM_BYTES(RAM_BYTES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // watches both streams and the config port, predicts and compares
  ptrpd_checker #(
    .RAM_BYTES(RAM_BYTES)
  ) row_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .run_over_i   (run_over),
    .error_count_o(fail_count),
    .pending_o    (rows_pending)
  );

  // receiver stall pattern: free running, long no-stall stretches included
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left  = $urandom_range(50, 300);
    end
    style_left--;
    case (stall_style)
      STALL_NONE:  m_axis_tready <= 1'b1;
      STALL_HALF:  m_axis_tready <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:     m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // watchdog: too long without any transaction on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] pack_item(input logic [8:0] addr, input logic [7:0] value,
                                            input logic [7:0] p0, input logic [7:0] p1,
                                            input logic [7:0] p2, input logic [7:0] p3,
                                            input logic [7:0] palette);
    return {7'd0, palette, p3, p2, p1, p0, value, addr};
  endfunction

  // one transaction; bursts of random length separated by random gaps
  task automatic send_item(input ptrpd_cmd_e cmd, input logic [63:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_WRITE) writes_sent++;
    else rows_sent++;
  endtask

  task automatic send_write(input logic [8:0] addr, input logic [7:0] value);
    send_item(CMD_WRITE, pack_item(addr, value, 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom)));
  endtask

  task automatic send_decode(input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
                             input logic [7:0] p3, input logic [7:0] palette);
    send_item(CMD_DECODE, pack_item(9'($urandom), 8'($urandom), p0, p1, p2, p3, palette));
  endtask

  // let the pipeline empty, then change the plane mode
  task automatic set_plane_mode(input logic four_planes);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= four_planes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_writes++;
  endtask

  // mostly writes and decodes around the low palettes, some anywhere and at limits
  task automatic run_random(input int unsigned count);
    logic [8:0]  addr;
    logic [7:0]  palette;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        addr = ($urandom_range(0, 1) == 1) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 127));
        send_write(addr, 8'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) palette = 8'($urandom_range(0, 3));
        else if (pick < 9) palette = 8'($urandom);
        else palette = 8'((9'd1 << $urandom_range(4, 8)) - $urandom_range(0, 1));
        send_decode(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), palette);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_WRITE;
    run_over      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, four planes first
    set_plane_mode(1'b1);
    send_decode(8'h00, 8'h00, 8'h00, 8'h00, 8'd0);     // every pixel backdrop
    send_decode(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0);     // cleared ram reads black
    send_write(9'd2, 8'hFF);
    send_write(9'd3, 8'hFF);                           // colour bit 15 set, must be dropped
    send_write(9'd4, 8'h1F);
    send_write(9'd5, 8'h00);
    send_write(9'd511, 8'hFF);
    send_write(9'd510, 8'h00);
    send_decode(8'hAA, 8'h55, 8'h00, 8'h00, 8'd0);     // indices one and two alternate
    send_decode(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd15);    // last entry inside the ram
    send_decode(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);   // far beyond the ram: magenta
    send_decode(8'h80, 8'h00, 8'h00, 8'h00, 8'd16);    // first palette past the ram
    send_decode(8'h01, 8'h02, 8'h04, 8'h08, 8'd31);

    // two planes: upper planes must be ignored
    set_plane_mode(1'b0);
    send_decode(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'd0);
    send_decode(8'hFF, 8'hFF, 8'h00, 8'h00, 8'd63);    // last entry inside the ram
    send_decode(8'h0F, 8'h3C, 8'hFF, 8'hFF, 8'd64);    // just past the ram
    send_decode(8'hF0, 8'h0F, 8'h00, 8'hFF, 8'd255);
    send_write(9'd256, 8'hA5);
    send_decode(8'hFF, 8'h00, 8'h00, 8'h00, 8'd32);    // entry 129 at bytes 258/259

    // random part, alternating plane modes
    for (int phase = 0; phase < 4; phase++) begin
      set_plane_mode(phase[0]);
      run_random(PHASE_ITEMS);
    end

    // drain and settle, then close out the leftover check
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    run_over <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("run covered %0d colour ram writes and %0d row decodes, %0d mode writes",
             writes_sent, rows_sent, mode_writes);
    $display("both plane modes, backdrop and out-of-range entries, stalls and gaps");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
